// ===== hw/rtl/mppt_pkg.sv =====
`default_nettype none
package mppt_pkg;

	// Sample format and averaging group size.
	localparam int ADC_BITS  = 12;
	localparam int AVG_SHIFT = 4;
	localparam int GROUP     = 1 << AVG_SHIFT;
	localparam int CNT_W     = (AVG_SHIFT > 0) ? AVG_SHIFT : 1;
	localparam int SUM_W     = ADC_BITS + AVG_SHIFT;
	localparam int CUR_W     = ADC_BITS + 1;
	localparam int PWR_W     = 2 * ADC_BITS + 1;

	// Duty and configuration widths.
	localparam int DUTY_W    = 16;
	localparam int STEP_W    = 8;
	localparam int PHASE_W   = 2;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	// Phase codes as reported on the phase output.
	localparam logic [PHASE_W-1:0] PH_START = 2'd0;
	localparam logic [PHASE_W-1:0] PH_SCAN  = 2'd1;
	localparam logic [PHASE_W-1:0] PH_TRACK = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CURRENT_OFFSET    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_STEP         = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX          = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_RESTART_DUTY = 2'd3;

	// Configuration reset values.
	localparam logic [ADC_BITS-1:0] RST_CURRENT_OFFSET    = 12'd3050;
	localparam logic [STEP_W-1:0]   RST_DUTY_STEP         = 8'd5;
	localparam logic [DUTY_W-1:0]   RST_DUTY_MAX          = 16'd4799;
	localparam logic [DUTY_W-1:0]   RST_SCAN_RESTART_DUTY = 16'd4000;

	// One averaged group, passed from the accumulator to the tracker.
	typedef struct packed {
		logic [ADC_BITS-1:0]     avg_v;
		logic signed [CUR_W-1:0] avg_i;
	} group_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mppt_accum.sv =====
`default_nettype none
module mppt_accum (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [mppt_pkg::ADC_BITS-1:0] voltage_sample,
	input  wire logic [mppt_pkg::ADC_BITS-1:0] current_sample,
	input  wire logic [mppt_pkg::ADC_BITS-1:0] current_offset,
	output logic                               grp_valid,
	input  wire logic                          grp_ready,
	output mppt_pkg::group_t                   grp
);
	import mppt_pkg::*;

	logic [CNT_W-1:0]    count_q;
	logic [SUM_W-1:0]    vsum_q;
	logic [SUM_W-1:0]    csum_q;
	logic [SUM_W-1:0]    vsum_next;
	logic [SUM_W-1:0]    csum_next;
	logic [ADC_BITS-1:0] avg_c;
	logic                last;
	logic                in_fire;

	// The last sample of a group needs room in the queue.
	assign last      = (count_q == CNT_W'(GROUP - 1));
	assign in_ready  = !last || grp_ready;
	assign in_fire   = in_valid && in_ready;
	assign grp_valid = in_valid && last;

	// Sums including the sample on the port.
	assign vsum_next = vsum_q + SUM_W'(voltage_sample);
	assign csum_next = csum_q + SUM_W'(current_sample);
	assign avg_c     = csum_next[SUM_W-1:AVG_SHIFT];

	// Averages of the completed group; current is offset corrected.
	assign grp.avg_v = vsum_next[SUM_W-1:AVG_SHIFT];
	assign grp.avg_i = $signed({1'b0, avg_c}) - $signed({1'b0, current_offset});

	// Accumulate samples and restart after each group.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			vsum_q  <= '0;
			csum_q  <= '0;
		end else if (in_fire) begin
			if (last) begin
				count_q <= '0;
				vsum_q  <= '0;
				csum_q  <= '0;
			end else begin
				count_q <= count_q + 1'b1;
				vsum_q  <= vsum_next;
				csum_q  <= csum_next;
			end
		end
	end

	a_group_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && last |=> count_q == '0 && vsum_q == '0 && csum_q == '0)
		else $error("accumulator did not restart after a group");

endmodule
`default_nettype wire

// ===== hw/rtl/mppt_grp_fifo.sv =====
`default_nettype none
module mppt_grp_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire mppt_pkg::group_t push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output mppt_pkg::group_t      pop_data
);
	import mppt_pkg::*;

	group_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push_fire;
	logic       pop_fire;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop_fire) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + 2'd1;
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("group queue count out of range");

endmodule
`default_nettype wire

// ===== hw/rtl/mppt_track.sv =====
`default_nettype none
module mppt_track (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               grp_valid,
	output logic                                    grp_ready,
	input  wire mppt_pkg::group_t                   grp,
	input  wire logic [mppt_pkg::STEP_W-1:0]        duty_step,
	input  wire logic [mppt_pkg::DUTY_W-1:0]        duty_max,
	input  wire logic [mppt_pkg::DUTY_W-1:0]        scan_restart_duty,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [mppt_pkg::DUTY_W-1:0]             duty_value,
	output logic [mppt_pkg::PHASE_W-1:0]            phase,
	output logic [mppt_pkg::ADC_BITS-1:0]           avg_voltage,
	output logic signed [mppt_pkg::CUR_W-1:0]       avg_current,
	output logic signed [mppt_pkg::PWR_W-1:0]       power_product
);
	import mppt_pkg::*;

	localparam int DS_W = DUTY_W + 2;

	// Tracker state.
	logic [PHASE_W-1:0]      phase_q;
	logic [DUTY_W-1:0]       duty_q;
	logic signed [PWR_W-1:0] prev_power_q;
	logic [ADC_BITS-1:0]     prev_v_q;

	// Stage 1: product.
	logic                    v_s1;
	logic [ADC_BITS-1:0]     avg_v_s1;
	logic signed [CUR_W-1:0] avg_i_s1;
	logic signed [PWR_W-1:0] power_s1;

	// Stage 2: differences and stepped duty.
	logic                    v_s2;
	logic [ADC_BITS-1:0]     avg_v_s2;
	logic signed [CUR_W-1:0] avg_i_s2;
	logic signed [PWR_W-1:0] power_s2;
	logic                    pnz_s2;
	logic signed [DS_W-1:0]  d_s2;

	// Output register.
	logic                    out_valid_q;
	logic [DUTY_W-1:0]       duty_out_q;
	logic [PHASE_W-1:0]      phase_out_q;
	logic [ADC_BITS-1:0]     avg_v_out_q;
	logic signed [CUR_W-1:0] avg_i_out_q;
	logic signed [PWR_W-1:0] power_out_q;

	logic                    pop_fire;
	logic                    commit;
	logic signed [PWR_W:0]   prod;
	logic signed [PWR_W:0]   pdiff;
	logic signed [CUR_W-1:0] vdiff;
	logic                    pnz;
	logic                    ppos;
	logic                    vnz;
	logic                    up;
	logic signed [DS_W-1:0]  d_step;
	logic [DUTY_W:0]         scan_inc;
	logic [DUTY_W-1:0]       duty_nx;
	logic [PHASE_W-1:0]      phase_nx;

	// One group at a time: the next pop waits for the previous commit.
	assign grp_ready = !v_s1 && !v_s2;
	assign pop_fire  = grp_valid && grp_ready;
	assign commit    = v_s2 && (!out_valid_q || out_ready);

	assign prod = $signed({1'b0, grp.avg_v}) * grp.avg_i;

	// Power and voltage change against the last tracked group.
	assign pdiff = {power_s1[PWR_W-1], power_s1} - {prev_power_q[PWR_W-1], prev_power_q};
	assign vdiff = $signed({1'b0, avg_v_s1}) - $signed({1'b0, prev_v_q});
	assign pnz   = (pdiff != '0);
	assign ppos  = pnz && !pdiff[PWR_W];
	assign vnz   = (vdiff != '0);
	// Rising power keeps the direction of the voltage change.
	assign up    = ppos ? vdiff[CUR_W-1] : (vnz && !vdiff[CUR_W-1]);

	always_comb begin
		d_step = $signed({2'b00, duty_q});
		if (vnz) begin
			if (up) begin
				d_step = $signed({2'b00, duty_q}) + $signed({{(DS_W-STEP_W){1'b0}}, duty_step});
			end else begin
				d_step = $signed({2'b00, duty_q}) - $signed({{(DS_W-STEP_W){1'b0}}, duty_step});
			end
		end
	end

	// Phase sequencing, scan increment and tracking clamp.
	assign scan_inc = {1'b0, duty_q} + {{DUTY_W{1'b0}}, 1'b1};

	always_comb begin
		duty_nx  = duty_q;
		phase_nx = phase_q;
		case (phase_q)
			PH_START: begin
				duty_nx  = '0;
				phase_nx = PH_SCAN;
			end
			PH_SCAN: begin
				if (scan_inc > {1'b0, duty_max}) begin
					duty_nx  = scan_restart_duty;
					phase_nx = PH_TRACK;
				end else begin
					duty_nx = scan_inc[DUTY_W-1:0];
				end
			end
			default: begin
				if (pnz_s2) begin
					if (d_s2 >= $signed({2'b00, duty_max})) begin
						duty_nx = duty_max;
					end else if (d_s2 <= $signed(DS_W'(0))) begin
						duty_nx = '0;
					end else begin
						duty_nx = d_s2[DUTY_W-1:0];
					end
				end
			end
		endcase
	end

	// Pipeline stages.
	always_ff @(posedge clk) begin
		if (pop_fire) begin
			avg_v_s1 <= grp.avg_v;
			avg_i_s1 <= grp.avg_i;
			power_s1 <= prod[PWR_W-1:0];
		end
		if (v_s1) begin
			avg_v_s2 <= avg_v_s1;
			avg_i_s2 <= avg_i_s1;
			power_s2 <= power_s1;
			pnz_s2   <= pnz;
			d_s2     <= d_step;
		end
		if (commit) begin
			duty_out_q  <= duty_nx;
			phase_out_q <= phase_nx;
			avg_v_out_q <= avg_v_s2;
			avg_i_out_q <= avg_i_s2;
			power_out_q <= power_s2;
		end
	end

	// Stage valids, result valid and tracker state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			out_valid_q  <= 1'b0;
			phase_q      <= PH_START;
			duty_q       <= '0;
			prev_power_q <= '0;
			prev_v_q     <= '0;
		end else begin
			v_s1 <= pop_fire;
			if (v_s1) begin
				v_s2 <= 1'b1;
			end else if (commit) begin
				v_s2 <= 1'b0;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (commit) begin
				phase_q <= phase_nx;
				duty_q  <= duty_nx;
				if (phase_q != PH_START && phase_q != PH_SCAN) begin
					prev_power_q <= power_s2;
					if (pnz_s2) begin
						prev_v_q <= avg_v_s2;
					end
				end
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign duty_value    = duty_out_q;
	assign phase         = phase_out_q;
	assign avg_voltage   = avg_v_out_q;
	assign avg_current   = avg_i_out_q;
	assign power_product = power_out_q;

	a_one_group: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s1 && v_s2))
		else $error("two groups in the tracker at once");

	a_track_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		commit && phase_q == PH_TRACK && pnz_s2 |=> duty_q <= $past(duty_max))
		else $error("tracked duty above maximum");

	a_phase_step: assert property (@(posedge clk) disable iff (!arst_n)
		commit && phase_q == PH_START |=> phase_q == PH_SCAN && duty_q == '0)
		else $error("start phase did not enter scan at zero duty");

endmodule
`default_nettype wire

// ===== hw/rtl/mppt_perturb_observe.sv =====
// Perturb-and-observe maximum power point tracker.
// Input channel (in_valid/in_ready): one voltage/current ADC sample pair per
// transfer. Pairs are averaged in groups of 16; the 16th pair of a group
// produces exactly one result, the other pairs produce none.
// Output channel (out_valid/out_ready): new PWM duty, phase (0 start, 1 scan,
// 2 track), averaged voltage, offset-corrected averaged current and their
// product.
// Throughput: one sample pair per cycle while in_ready is high; in_ready
// drops only on the last pair of a group when the group queue is full. The
// tracker handles one group at a time (multiply, compare and step, clamp
// and commit). A group's result passes from the group queue through the
// stage 1 and stage 2 registers to the output register.
// When the receiver stalls, the result waits in the output register; the
// tracker holds one more group and the two-entry group queue two further, so
// sampling continues for three more complete groups, after which in_ready
// drops on the last pair of the next group.
// Reset clears all sums, the phase, duty and previous power and voltage,
// and loads the configuration defaults. The user must write configuration
// (cfg_we/cfg_index/cfg_data) only while idle; the block does not enforce it.
`default_nettype none
module mppt_perturb_observe (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [mppt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [mppt_pkg::CFG_W-1:0]          cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [mppt_pkg::ADC_BITS-1:0]       voltage_sample,
	input  wire logic [mppt_pkg::ADC_BITS-1:0]       current_sample,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [mppt_pkg::DUTY_W-1:0]              duty_value,
	output logic [mppt_pkg::PHASE_W-1:0]             phase,
	output logic [mppt_pkg::ADC_BITS-1:0]            avg_voltage,
	output logic signed [mppt_pkg::CUR_W-1:0]        avg_current,
	output logic signed [mppt_pkg::PWR_W-1:0]        power_product
);
	import mppt_pkg::*;

	logic [ADC_BITS-1:0] current_offset_q;
	logic [STEP_W-1:0]   duty_step_q;
	logic [DUTY_W-1:0]   duty_max_q;
	logic [DUTY_W-1:0]   scan_restart_q;

	logic   acc_valid;
	logic   acc_ready;
	group_t acc_grp;
	logic   q_valid;
	logic   q_ready;
	group_t q_grp;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_offset_q <= RST_CURRENT_OFFSET;
			duty_step_q      <= RST_DUTY_STEP;
			duty_max_q       <= RST_DUTY_MAX;
			scan_restart_q   <= RST_SCAN_RESTART_DUTY;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CURRENT_OFFSET:    current_offset_q <= cfg_data[ADC_BITS-1:0];
				REG_DUTY_STEP:         duty_step_q      <= cfg_data[STEP_W-1:0];
				REG_DUTY_MAX:          duty_max_q       <= cfg_data[DUTY_W-1:0];
				REG_SCAN_RESTART_DUTY: scan_restart_q   <= cfg_data[DUTY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Front: sample accumulation and averaging.
	mppt_accum u_accum (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.voltage_sample (voltage_sample),
		.current_sample (current_sample),
		.current_offset (current_offset_q),
		.grp_valid      (acc_valid),
		.grp_ready      (acc_ready),
		.grp            (acc_grp)
	);

	// Queue of completed groups.
	mppt_grp_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (acc_valid),
		.push_ready (acc_ready),
		.push_data  (acc_grp),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_grp)
	);

	// Back: power, phase sequencing and duty update.
	mppt_track u_track (
		.clk               (clk),
		.arst_n            (arst_n),
		.grp_valid         (q_valid),
		.grp_ready         (q_ready),
		.grp               (q_grp),
		.duty_step         (duty_step_q),
		.duty_max          (duty_max_q),
		.scan_restart_duty (scan_restart_q),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.duty_value        (duty_value),
		.phase             (phase),
		.avg_voltage       (avg_voltage),
		.avg_current       (avg_current),
		.power_product     (power_product)
	);

endmodule
`default_nettype wire
